// File: rtl/core/jet_pkg.sv
// ----------------------------------------------------------------------------
// jet_pkg: shared types and constants for the Julia escape-time core
// Number formats, register map, reset values, sequencer states and the
// saturation helper used by the update step.
// ----------------------------------------------------------------------------
package jet_pkg;

  // Field widths
  localparam int ZW   = 32;   // z components, signed Q14.18
  localparam int CW   = 22;   // c components, signed Q4.18
  localparam int RW   = 25;   // escape radius, unsigned Q7.18
  localparam int IW   = 16;   // iteration count / step index
  localparam int FRAC = 18;   // fraction bits

  // Shared multiplier: signed operands, product kept to 64 bits
  localparam int MW   = 33;
  localparam int PW   = 64;
  localparam int R2W  = 2 * RW;   // squared radius
  localparam int NW   = 48;       // update sum before saturation

  // Register map (index = paddr[3:2])
  localparam int AW = 4;
  localparam logic [1:0] REG_C_REAL    = 2'd0;
  localparam logic [1:0] REG_C_IMAG    = 2'd1;
  localparam logic [1:0] REG_RADIUS    = 2'd2;
  localparam logic [1:0] REG_MAX_ITER  = 2'd3;

  // Reset values
  localparam logic signed [CW-1:0] C_REAL_RST   = -22'sd104858;
  localparam logic signed [CW-1:0] C_IMAG_RST   = 22'sd157286;
  localparam logic        [RW-1:0] RADIUS_RST   = 25'd23356824;
  localparam logic        [IW-1:0] MAX_ITER_RST = 16'd1000;

  // Sequencer states
  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_R2   = 7'b0000010,
    ST_RR   = 7'b0000100,
    ST_II   = 7'b0001000,
    ST_RI   = 7'b0010000,
    ST_UPD  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  // Clamp a sum to the signed 32-bit range
  function automatic logic signed [ZW-1:0] sat_z(input logic signed [NW-1:0] x);
    logic signed [NW-1:0] hi;
    logic signed [NW-1:0] lo;
    hi = NW'(signed'({1'b0, {(ZW-1){1'b1}}}));
    lo = -hi - NW'(signed'(1));
    if (x > hi) begin
      sat_z = {1'b0, {(ZW-1){1'b1}}};
    end else if (x < lo) begin
      sat_z = {1'b1, {(ZW-1){1'b0}}};
    end else begin
      sat_z = x[ZW-1:0];
    end
  endfunction

endpackage

// File: rtl/core/jet_mul.sv
// ----------------------------------------------------------------------------
// jet_mul: shared signed multiplier
// One 33x33 signed multiply per cycle with a registered 64-bit product.
// ----------------------------------------------------------------------------
module jet_mul (
  input  logic                            clk,
  input  logic signed [jet_pkg::MW-1:0]   a,
  input  logic signed [jet_pkg::MW-1:0]   b,
  output logic signed [jet_pkg::PW-1:0]   prod_r
);
  import jet_pkg::*;

  logic signed [2*MW-1:0] full;

  // Form the exact product, keep the low 64 bits (all values fit)
  assign full = a * b;

  always_ff @(posedge clk) begin
    prod_r <= signed'(full[PW-1:0]);
  end

endmodule

// File: rtl/core/julia_escape_time_core.sv
// ----------------------------------------------------------------------------
// julia_escape_time_core: Julia set escape-time iterator
// Iterates z = z*z + c on a Q14.18 start point and reports the first escape.
// ----------------------------------------------------------------------------
// One start point is taken per input beat and one result beat comes out for
// it. All products go through a single shared 33x33 multiplier, so each update
// of z steps through re*re, im*im, re*im and then the update; the squares of
// the new z are reused as the magnitude test of the previous update. in_tready
// is high only while the sequencer is idle; the finished result sits in an
// output register until taken, and the next point is accepted meanwhile.
// Configuration writes must happen while the core is idle.
// ----------------------------------------------------------------------------
module julia_escape_time_core (
  input  logic        clk,
  input  logic        rst_n,
  // Start point beats
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,    // [31:0] start_real, [63:32] start_imag
  // Result beats
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [15:0] escape_step
  output logic        out_tuser,   // [0] escaped
  // Configuration port
  input  logic                    cfg_psel,
  input  logic                    cfg_penable,
  input  logic                    cfg_pwrite,
  input  logic [jet_pkg::AW-1:0]  cfg_paddr,
  input  logic [31:0]             cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);
  import jet_pkg::*;

  // Configuration registers
  logic signed [CW-1:0] c_real_r;
  logic signed [CW-1:0] c_imag_r;
  logic        [RW-1:0] radius_r;
  logic        [IW-1:0] max_iter_r;
  logic                 cfg_wr;
  logic [1:0]           cfg_idx;

  // Sequencer and datapath
  state_t               state_r, state_nxt;
  logic signed [ZW-1:0] re_r, re_nxt;
  logic signed [ZW-1:0] im_r, im_nxt;
  logic        [R2W-1:0] r2_r, r2_nxt;
  logic signed [PW-1:0] rr_r, rr_nxt;
  logic signed [PW-1:0] diff_r, diff_nxt;
  logic        [IW-1:0] cnt_r, cnt_nxt;
  logic        [IW-1:0] res_step_r, res_step_nxt;
  logic                 res_esc_r, res_esc_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic        [IW-1:0] out_step_r, out_step_nxt;
  logic                 out_esc_r, out_esc_nxt;

  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod_r;
  logic        [PW:0]   mag;
  logic                 esc_hit;
  logic signed [PW-1:0] nr_shift, ni_shift;
  logic signed [NW-1:0] nr_sum, ni_sum;
  logic                 in_acc, out_acc, out_load;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_valid_r && out_tready;

  // Configuration writes and reads
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_real_r   <= C_REAL_RST;
      c_imag_r   <= C_IMAG_RST;
      radius_r   <= RADIUS_RST;
      max_iter_r <= MAX_ITER_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_C_REAL:   c_real_r   <= signed'(cfg_pwdata[CW-1:0]);
        REG_C_IMAG:   c_imag_r   <= signed'(cfg_pwdata[CW-1:0]);
        REG_RADIUS:   radius_r   <= cfg_pwdata[RW-1:0];
        REG_MAX_ITER: max_iter_r <= cfg_pwdata[IW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_C_REAL:   cfg_prdata = 32'(c_real_r);
      REG_C_IMAG:   cfg_prdata = 32'(c_imag_r);
      REG_RADIUS:   cfg_prdata = {{(32-RW){1'b0}}, radius_r};
      REG_MAX_ITER: cfg_prdata = {{(32-IW){1'b0}}, max_iter_r};
      default:      cfg_prdata = '0;
    endcase
  end

  // Pick the multiplier operands for this step
  always_comb begin
    case (state_r)
      ST_R2: begin
        mul_a = signed'({{(MW-RW){1'b0}}, radius_r});
        mul_b = signed'({{(MW-RW){1'b0}}, radius_r});
      end
      ST_RR: begin
        mul_a = MW'(re_r);
        mul_b = MW'(re_r);
      end
      ST_II: begin
        mul_a = MW'(im_r);
        mul_b = MW'(im_r);
      end
      ST_RI: begin
        mul_a = MW'(re_r);
        mul_b = MW'(im_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  jet_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  // Magnitude of the last update: rr_r + ii (ii is in the product register)
  assign mag     = {1'b0, rr_r} + {1'b0, prod_r};
  assign esc_hit = mag > {{(PW+1-R2W){1'b0}}, r2_r};

  // Update terms: floor shifts, add c
  assign nr_shift = diff_r >>> FRAC;
  assign ni_shift = prod_r >>> (FRAC - 1);
  assign nr_sum   = signed'(nr_shift[NW-1:0]) + NW'(c_real_r);
  assign ni_sum   = signed'(ni_shift[NW-1:0]) + NW'(c_imag_r);

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    re_nxt       = re_r;
    im_nxt       = im_r;
    r2_nxt       = r2_r;
    rr_nxt       = rr_r;
    diff_nxt     = diff_r;
    cnt_nxt      = cnt_r;
    res_step_nxt = res_step_r;
    res_esc_nxt  = res_esc_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          re_nxt  = signed'(in_tdata[ZW-1:0]);
          im_nxt  = signed'(in_tdata[2*ZW-1:ZW]);
          cnt_nxt = '0;
          if (max_iter_r == '0) begin
            res_step_nxt = '0;
            res_esc_nxt  = 1'b0;
            state_nxt    = ST_DONE;
          end else begin
            state_nxt = ST_R2;
          end
        end
      end
      ST_R2: begin
        state_nxt = ST_RR;
      end
      ST_RR: begin
        // squared radius arrives on the first pass only
        if (cnt_r == '0) begin
          r2_nxt = prod_r[R2W-1:0];
        end
        state_nxt = ST_II;
      end
      ST_II: begin
        rr_nxt    = prod_r;
        state_nxt = ST_RI;
      end
      ST_RI: begin
        diff_nxt = rr_r - prod_r;
        if (cnt_r != '0 && esc_hit) begin
          res_step_nxt = cnt_r - IW'(1);
          res_esc_nxt  = 1'b1;
          state_nxt    = ST_DONE;
        end else if (cnt_r == max_iter_r) begin
          res_step_nxt = '0;
          res_esc_nxt  = 1'b0;
          state_nxt    = ST_DONE;
        end else begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        re_nxt    = sat_z(nr_sum);
        im_nxt    = sat_z(ni_sum);
        cnt_nxt   = cnt_r + IW'(1);
        state_nxt = ST_RR;
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register: load a finished result, drop it once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_step_nxt  = out_step_r;
    out_esc_nxt   = out_esc_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_step_nxt  = res_step_r;
      out_esc_nxt   = res_esc_r;
    end else if (out_acc) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    re_r       <= re_nxt;
    im_r       <= im_nxt;
    r2_r       <= r2_nxt;
    rr_r       <= rr_nxt;
    diff_r     <= diff_nxt;
    cnt_r      <= cnt_nxt;
    res_step_r <= res_step_nxt;
    res_esc_r  <= res_esc_nxt;
    out_step_r <= out_step_nxt;
    out_esc_r  <= out_esc_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_step_r;
  assign out_tuser  = out_esc_r;

endmodule
